### sv/drs_pkg.sv
// Shared types and constants for the disk request scheduler.
// Holds the transaction structs, the sequencer states and the operation codes.
// No dependencies.
`default_nettype none

package drs_pkg;

    // Fixed widths of the transaction fields.
    localparam int TAG_PORT_W   = 8;
    localparam int BLOCK_PORT_W = 32;
    localparam int TICK_W       = 32;
    localparam int PRIO_W       = 2;
    localparam int COUNT_PORT_W = 8;

    // Defaults for the top-level parameters.
    localparam int DEF_QUEUE_DEPTH     = 128;
    localparam int DEF_PRIORITY_LEVELS = 4;
    localparam int DEF_BLOCK_BITS      = 32;
    localparam int DEF_TAG_BITS        = 8;

    // Operation codes carried in the op field.
    localparam logic OP_SUBMIT   = 1'b0;
    localparam logic OP_COMPLETE = 1'b1;

    // Selection policy within the top priority level.
    localparam logic POLICY_FCFS = 1'b0;
    localparam logic POLICY_SSTF = 1'b1;

    typedef struct packed {
        logic                    op;
        logic [TAG_PORT_W-1:0]   req_tag;
        logic                    req_write;
        logic [BLOCK_PORT_W-1:0] req_block;
        logic [PRIO_W-1:0]       req_priority;
        logic [TICK_W-1:0]       req_tick;
    } req_t;

    typedef struct packed {
        logic                    accepted;
        logic                    issue_valid;
        logic [TAG_PORT_W-1:0]   issue_tag;
        logic                    issue_write;
        logic [BLOCK_PORT_W-1:0] issue_block;
        logic [TICK_W-1:0]       issue_tick;
        logic [COUNT_PORT_W-1:0] queue_count;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_OUT
    } sched_state_t;

endpackage

`default_nettype wire

### sv/disk_request_scheduler.sv
// Disk request scheduler top level: request queue memory, selection scan and compaction.
// Depends on drs_pkg for the transaction structs, state enum and codes.
//
// The block keeps an arrival-ordered queue of up to QUEUE_DEPTH disk requests in an
// internal memory and answers every accepted transaction with exactly one result
// transaction. A submit appends a request (accepted is 0 when the queue is full); a
// completion clears the busy flag. When nothing is in flight and requests wait, the
// block picks the entry with the lowest priority value; within that level it takes
// the oldest (policy 0) or the one nearest the current head position, earliest entry
// on a tie (policy 1). The chosen entry is removed, the head moves to its block and
// the block goes busy. The work is done by a small sequencer around one memory read
// port and one priority/distance compare unit: a scan pass reads every queued entry
// once, then a compaction pass moves each later entry down by one slot. When nothing
// is issued, the block skips both passes and goes straight to the result. The input
// is not ready from acceptance until the result transaction is taken. The policy
// register may be written at any time through the cfg port and is sampled during
// the scan, so it should only change while the block is idle. There is no clearing
// pass after reset; queue slots are only read below the fill count.
`default_nettype none

module disk_request_scheduler
    import drs_pkg::*;
#(
    parameter int QUEUE_DEPTH     = DEF_QUEUE_DEPTH,
    parameter int PRIORITY_LEVELS = DEF_PRIORITY_LEVELS,
    parameter int BLOCK_BITS      = DEF_BLOCK_BITS,
    parameter int TAG_BITS        = DEF_TAG_BITS
) (
    input  wire logic clk,
    input  wire logic rst_n,

    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req_data,

    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp_data,

    input  wire logic cfg_valid,
    output logic      cfg_ready,
    input  wire logic cfg_policy
);

    // Stored widths: the ports carry at most 32 block bits and 8 tag bits.
    localparam int BLK_W  = (BLOCK_BITS < BLOCK_PORT_W) ? BLOCK_BITS : BLOCK_PORT_W;
    localparam int TAG_W  = (TAG_BITS < TAG_PORT_W) ? TAG_BITS : TAG_PORT_W;
    localparam int META_W = PRIO_W + 1 + TAG_W;
    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    // Highest priority value that is stored; larger requested values saturate.
    localparam logic [PRIO_W-1:0] PRIO_MAX = (PRIORITY_LEVELS > (1 << PRIO_W)) ?
                                             {PRIO_W{1'b1}} : PRIO_W'(PRIORITY_LEVELS - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(QUEUE_DEPTH);

    // Queue memory: one write port and one registered read port.
    logic [BLK_W-1:0]  mem_block [QUEUE_DEPTH];
    logic [TICK_W-1:0] mem_tick  [QUEUE_DEPTH];
    logic [META_W-1:0] mem_meta  [QUEUE_DEPTH];

    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa;
    logic [BLK_W-1:0]  mem_wblock;
    logic [TICK_W-1:0] mem_wtick;
    logic [META_W-1:0] mem_wmeta;
    logic [IDX_W-1:0]  mem_ra;

    logic [BLK_W-1:0]  rd_block_reg;
    logic [TICK_W-1:0] rd_tick_reg;
    logic [META_W-1:0] rd_meta_reg;

    // Sequencer and architectural state.
    sched_state_t     state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [BLK_W-1:0] head_reg, head_next;
    logic             busy_reg, busy_next;
    logic             policy_reg;
    logic [CNT_W-1:0] ptr_reg, ptr_next;

    // Read pipeline stage: the memory data of rd_idx_reg is in the rd_*_reg registers.
    logic             rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;

    // Distance stage feeding the compare unit.
    logic              s2_vld_reg, s2_vld_next;
    logic [IDX_W-1:0]  s2_idx_reg, s2_idx_next;
    logic [BLK_W-1:0]  s2_dist_reg, s2_dist_next;
    logic [BLK_W-1:0]  s2_block_reg, s2_block_next;
    logic [TICK_W-1:0] s2_tick_reg, s2_tick_next;
    logic [META_W-1:0] s2_meta_reg, s2_meta_next;

    // Best candidate seen so far in the scan.
    logic              best_vld_reg, best_vld_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [BLK_W-1:0]  best_dist_reg, best_dist_next;
    logic [BLK_W-1:0]  best_block_reg, best_block_next;
    logic [TICK_W-1:0] best_tick_reg, best_tick_next;
    logic [META_W-1:0] best_meta_reg, best_meta_next;

    rsp_t rsp_reg, rsp_next;

    // Combinational helpers.
    logic              req_fire;
    logic              submit_ok;
    logic              busy_after;
    logic [CNT_W-1:0]  count_after;
    logic [PRIO_W-1:0] prio_in;
    logic [BLK_W-1:0]  rd_dist;
    logic [PRIO_W-1:0] s2_prio;
    logic [PRIO_W-1:0] best_prio;
    logic              cand_better;
    logic [CNT_W-1:0]  count_dec;

    assign req_fire    = req_valid && req_ready;
    assign submit_ok   = (req_data.op == OP_SUBMIT) && (count_reg != CNT_FULL);
    assign busy_after  = busy_reg && (req_data.op != OP_COMPLETE);
    assign count_after = count_reg + CNT_W'(submit_ok);
    assign prio_in     = (req_data.req_priority > PRIO_MAX) ? PRIO_MAX : req_data.req_priority;
    assign count_dec   = count_reg - CNT_W'(1);

    // The shared compare unit: priority first, then seek distance under shortest seek.
    // Strict comparisons keep the earlier entry on every tie.
    assign rd_dist   = (head_reg >= rd_block_reg) ? (head_reg - rd_block_reg)
                                                  : (rd_block_reg - head_reg);
    assign s2_prio   = s2_meta_reg[META_W-1 -: PRIO_W];
    assign best_prio = best_meta_reg[META_W-1 -: PRIO_W];
    assign cand_better = !best_vld_reg
                      || (s2_prio < best_prio)
                      || ((s2_prio == best_prio) && (policy_reg == POLICY_SSTF)
                          && (s2_dist_reg < best_dist_reg));

    assign rsp_data  = rsp_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        busy_next       = busy_reg;
        ptr_next        = ptr_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = ptr_reg[IDX_W-1:0];
        s2_vld_next     = 1'b0;
        s2_idx_next     = rd_idx_reg;
        s2_dist_next    = rd_dist;
        s2_block_next   = rd_block_reg;
        s2_tick_next    = rd_tick_reg;
        s2_meta_next    = rd_meta_reg;
        best_vld_next   = best_vld_reg;
        best_idx_next   = best_idx_reg;
        best_dist_next  = best_dist_reg;
        best_block_next = best_block_reg;
        best_tick_next  = best_tick_reg;
        best_meta_next  = best_meta_reg;
        rsp_next        = rsp_reg;

        req_ready  = 1'b0;
        rsp_valid  = 1'b0;
        mem_we     = 1'b0;
        mem_wa     = count_reg[IDX_W-1:0];
        mem_wblock = req_data.req_block[BLK_W-1:0];
        mem_wtick  = req_data.req_tick;
        mem_wmeta  = {prio_in, req_data.req_write, req_data.req_tag[TAG_W-1:0]};
        mem_ra     = ptr_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_fire)
                begin
                    mem_we               = submit_ok;
                    count_next           = count_after;
                    busy_next            = busy_after;
                    rsp_next             = '0;
                    rsp_next.accepted    = submit_ok;
                    rsp_next.queue_count = COUNT_PORT_W'(count_after);
                    if (!busy_after && (count_after != '0))
                    begin
                        ptr_next      = '0;
                        best_vld_next = 1'b0;
                        state_next    = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end

            ST_SCAN:
            begin
                if (ptr_reg < count_reg)
                begin
                    rd_vld_next = 1'b1;
                    ptr_next    = ptr_reg + CNT_W'(1);
                end
                s2_vld_next = rd_vld_reg;
                if (s2_vld_reg && cand_better)
                begin
                    best_vld_next   = 1'b1;
                    best_idx_next   = s2_idx_reg;
                    best_dist_next  = s2_dist_reg;
                    best_block_next = s2_block_reg;
                    best_tick_next  = s2_tick_reg;
                    best_meta_next  = s2_meta_reg;
                end
                if ((ptr_reg == count_reg) && !rd_vld_reg && !s2_vld_reg)
                begin
                    // Compaction starts with the entry just after the chosen one.
                    ptr_next   = CNT_W'(best_idx_reg) + CNT_W'(1);
                    state_next = ST_SHIFT;
                end
            end

            ST_SHIFT:
            begin
                if (ptr_reg < count_reg)
                begin
                    rd_vld_next = 1'b1;
                    ptr_next    = ptr_reg + CNT_W'(1);
                end
                if (rd_vld_reg)
                begin
                    mem_we     = 1'b1;
                    mem_wa     = rd_idx_reg - IDX_W'(1);
                    mem_wblock = rd_block_reg;
                    mem_wtick  = rd_tick_reg;
                    mem_wmeta  = rd_meta_reg;
                end
                if ((ptr_reg >= count_reg) && !rd_vld_reg)
                begin
                    count_next           = count_dec;
                    head_next            = best_block_reg;
                    busy_next            = 1'b1;
                    rsp_next.issue_valid = 1'b1;
                    rsp_next.issue_tag   = TAG_PORT_W'(best_meta_reg[TAG_W-1:0]);
                    rsp_next.issue_write = best_meta_reg[TAG_W];
                    rsp_next.issue_block = BLOCK_PORT_W'(best_block_reg);
                    rsp_next.issue_tick  = best_tick_reg;
                    rsp_next.queue_count = COUNT_PORT_W'(count_dec);
                    state_next           = ST_OUT;
                end
            end

            ST_OUT:
            begin
                rsp_valid = 1'b1;
                if (rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Queue memory ports.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_block[mem_wa] <= mem_wblock;
            mem_tick[mem_wa]  <= mem_wtick;
            mem_meta[mem_wa]  <= mem_wmeta;
        end
        rd_block_reg <= mem_block[mem_ra];
        rd_tick_reg  <= mem_tick[mem_ra];
        rd_meta_reg  <= mem_meta[mem_ra];
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            head_reg     <= '0;
            busy_reg     <= 1'b0;
            policy_reg   <= POLICY_FCFS;
            ptr_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
            best_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            head_reg     <= head_next;
            busy_reg     <= busy_next;
            ptr_reg      <= ptr_next;
            rd_vld_reg   <= rd_vld_next;
            s2_vld_reg   <= s2_vld_next;
            best_vld_reg <= best_vld_next;
            if (cfg_valid && cfg_ready)
            begin
                policy_reg <= cfg_policy;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= rd_idx_next;
        s2_idx_reg     <= s2_idx_next;
        s2_dist_reg    <= s2_dist_next;
        s2_block_reg   <= s2_block_next;
        s2_tick_reg    <= s2_tick_next;
        s2_meta_reg    <= s2_meta_next;
        best_idx_reg   <= best_idx_next;
        best_dist_reg  <= best_dist_next;
        best_block_reg <= best_block_next;
        best_tick_reg  <= best_tick_next;
        best_meta_reg  <= best_meta_next;
        rsp_reg        <= rsp_next;
    end

endmodule

`default_nettype wire

### sv/drs_checker.sv
// Port-level checker for the disk request scheduler, with its bind statement.
// Depends on drs_pkg and attaches to disk_request_scheduler.
`default_nettype none

module drs_checker
    import drs_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_ready,
    input wire req_t req_data,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire rsp_t rsp_data
);

    // A pending result transaction holds its value until it is taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result transaction changed before it was taken");

    // The input drops ready after an accepted request, and stays low while a result is pending.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("input ready right after an accepted transaction");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
        else $error("input ready while a result transaction is pending");

    // Without an issue, the issue fields read as zero.
    a_no_issue_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.issue_valid |->
            (rsp_data.issue_tag == '0) && (rsp_data.issue_write == 1'b0)
            && (rsp_data.issue_block == '0) && (rsp_data.issue_tick == '0))
        else $error("issue fields set on a result without an issue");

endmodule

bind disk_request_scheduler drs_checker u_drs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
);

`default_nettype wire
